[sv/lpr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

    localparam int CFG_W    = 6;
    localparam int FILLED_W = 6;
    localparam int FAULT_W  = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX     = '1;
    localparam logic [CFG_W-1:0]   FRAMES_RESET  = CFG_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } lpr_state_t;

    typedef enum logic {
        PASS_SEARCH,
        PASS_EVICT
    } lpr_pass_t;

endpackage

[sv/lru_page_replacement.sv]
// LRU page replacement: top level with sweep sequencer and result register.
// Fully associative LRU replacement over up to MAX_FRAME_SLOTS frames, kept in a
// frame RAM with one write port and one registered read port as a stack ordered
// least to most recently used. A transaction sweeps the resident frames once,
// one RAM read per cycle, comparing against the page and shifting younger entries
// down behind a hit; a miss with all frames in use runs a second sweep that
// evicts slot 0 and shifts the rest. The next transaction can be accepted in the
// cycle after the result is loaded; a held output register delays that load.
// The input is stalled from acceptance until the result is loaded; a finished
// result waits in the output register while the next transaction is taken.
module lru_page_replacement #(
    parameter int MAX_FRAME_SLOTS = 32,
    parameter int PAGE_BITS       = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]     frames_in_use,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PAGE_BITS-1:0]          page,
    input  logic                          end_of_trace,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic                          evicted_valid,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [lpr_pkg::FAULT_W-1:0]   fault_count,
    output logic [lpr_pkg::FILLED_W-1:0]  frames_filled
);

    import lpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_SLOTS + 1);
    localparam int IDX_W = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
    localparam logic [6:0] MAX7 = 7'(MAX_FRAME_SLOTS);

    lpr_state_t state_reg, state_next;
    lpr_pass_t  pass_reg, pass_next;

    logic [CFG_W-1:0]     frames_reg, frames_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 eot_reg, eot_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic                 moving_reg, moving_next;
    logic                 hit_reg, hit_next;
    logic                 evv_reg, evv_next;
    logic [PAGE_BITS-1:0] evp_reg, evp_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 hit_o_reg, hit_o_next;
    logic                 evv_o_reg, evv_o_next;
    logic [PAGE_BITS-1:0] evp_o_reg, evp_o_next;
    logic [FAULT_W-1:0]   fault_o_reg, fault_o_next;
    logic [FILLED_W-1:0]  filled_o_reg, filled_o_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [PAGE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [PAGE_BITS-1:0] rd_data;

    logic [6:0]           lim7;
    logic [CNT_W-1:0]     used_m1;
    logic                 match;
    logic                 out_free;

    lpr_frame_ram #(
        .DEPTH (MAX_FRAME_SLOTS),
        .WIDTH (PAGE_BITS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign hit           = hit_o_reg;
    assign evicted_valid = evv_o_reg;
    assign evicted_page  = evp_o_reg;
    assign fault_count   = fault_o_reg;
    assign frames_filled = filled_o_reg;

    // Effective frame limit: 0 acts as 1, clamp at the slot count
    always_comb
    begin
        lim7 = 7'(frames_reg);
        if (lim7 == 7'd0)
        begin
            lim7 = 7'd1;
        end
        if (lim7 > MAX7)
        begin
            lim7 = MAX7;
        end
    end

    assign used_m1  = used_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || !out_stall;
    assign match    = (pass_reg == PASS_EVICT) ? (pidx_reg == '0) : (rd_data == page_reg);

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        frames_next   = frames_reg;
        page_next     = page_reg;
        eot_next      = eot_reg;
        used_next     = used_reg;
        fault_next    = fault_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        moving_next   = moving_reg;
        hit_next      = hit_reg;
        evv_next      = evv_reg;
        evp_next      = evp_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_o_next    = hit_o_reg;
        evv_o_next    = evv_o_reg;
        evp_o_next    = evp_o_reg;
        fault_o_next  = fault_o_reg;
        filled_o_next = filled_o_reg;
        mem_we        = 1'b0;
        mem_waddr     = pidx_reg - IDX_W'(1);
        mem_wdata     = rd_data;
        rd_addr       = issue_reg[IDX_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            frames_next = frames_in_use;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next   = page;
                    eot_next    = end_of_trace;
                    pass_next   = PASS_SEARCH;
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    moving_next = 1'b0;
                    hit_next    = 1'b0;
                    evv_next    = 1'b0;
                    evp_next    = '0;
                    state_next  = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                if (issue_reg < used_reg)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // read data back: shift down behind the match
                if (pend_reg)
                begin
                    if (moving_reg)
                    begin
                        mem_we = 1'b1;
                    end
                    else if (match)
                    begin
                        moving_next = 1'b1;
                        if (pass_reg == PASS_EVICT)
                        begin
                            evv_next = 1'b1;
                            evp_next = rd_data;
                        end
                    end
                end

                if (!pend_reg && (issue_reg == used_reg))
                begin
                    if (moving_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = used_m1[IDX_W-1:0];
                        mem_wdata  = page_reg;
                        hit_next   = (pass_reg == PASS_SEARCH);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (fault_reg != FAULT_MAX)
                        begin
                            fault_next = fault_reg + FAULT_W'(1);
                        end
                        if (7'(used_reg) < lim7)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = used_reg[IDX_W-1:0];
                            mem_wdata  = page_reg;
                            used_next  = used_reg + CNT_W'(1);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pass_next   = PASS_EVICT;
                            issue_next  = '0;
                            moving_next = 1'b0;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_o_next     = hit_reg;
                    evv_o_next     = evv_reg;
                    evp_o_next     = evp_reg;
                    fault_o_next   = fault_reg;
                    filled_o_next  = FILLED_W'(used_reg);
                    if (eot_reg)
                    begin
                        used_next  = '0;
                        fault_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_SEARCH;
            frames_reg    <= FRAMES_RESET;
            used_reg      <= '0;
            fault_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            frames_reg    <= frames_next;
            used_reg      <= used_next;
            fault_reg     <= fault_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            moving_reg    <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        eot_reg      <= eot_next;
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        evv_reg      <= evv_next;
        evp_reg      <= evp_next;
        hit_o_reg    <= hit_o_next;
        evv_o_reg    <= evv_o_next;
        evp_o_reg    <= evp_o_next;
        fault_o_reg  <= fault_o_next;
        filled_o_reg <= filled_o_next;
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_FRAME_SLOTS))
        else $error("fill count beyond slot count");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("frame store written while idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SWEEP && pass_reg == PASS_SEARCH))
        else $error("accepted transaction did not start a search");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_o_reg && evv_o_reg))
        else $error("hit reported together with an eviction");

    a_evict_only_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && pass_reg == PASS_SEARCH) |-> !evv_reg)
        else $error("eviction flagged during the search pass");

endmodule

[sv/lpr_frame_ram.sv]
// Frame store: single write port, single registered read port.
module lpr_frame_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/lpr_checker.sv]
// Checker for the LRU page replacement block: predicts each reference and compares results.
module lpr_checker #(
    parameter int MAX_FRAME_SLOTS = 32,
    parameter int PAGE_BITS       = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]     frames_in_use,

    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [PAGE_BITS-1:0]          page,
    input  logic                          end_of_trace,

    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          hit,
    input  logic                          evicted_valid,
    input  logic [PAGE_BITS-1:0]          evicted_page,
    input  logic [lpr_pkg::FAULT_W-1:0]   fault_count,
    input  logic [lpr_pkg::FILLED_W-1:0]  frames_filled,

    output int unsigned                   fail_count,
    output int unsigned                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    typedef struct packed {
        logic                  is_hit;
        logic                  ev_valid;
        logic [PAGE_BITS-1:0]  ev_page;
        logic [FAULT_W-1:0]    faults;
        logic [FILLED_W-1:0]   filled;
    } lru_outcome_t;

    logic [PAGE_BITS-1:0] resident [MAX_FRAME_SLOTS];
    logic [CFG_W-1:0]     frames_cfg;
    int unsigned          filled_frames;
    logic [FAULT_W-1:0]   trace_faults;
    lru_outcome_t         expected_outcomes [$];
    int unsigned          mismatches = 0;

    task automatic predict_reference(input logic [PAGE_BITS-1:0] pg, input logic eot);
        lru_outcome_t r;
        int           limit;
        int           used;
        int           pos;
        r     = '0;
        limit = int'(frames_cfg);
        if (limit < 1)
            limit = 1;
        if (limit > MAX_FRAME_SLOTS)
            limit = MAX_FRAME_SLOTS;
        used = int'(filled_frames);
        if (used > MAX_FRAME_SLOTS)
            used = MAX_FRAME_SLOTS;
        pos = used;
        for (int k = 0; k < used; k++)
        begin
            if (resident[k] == pg)
            begin
                pos = k;
                break;
            end
        end
        if (pos < used)
        begin
            r.is_hit = 1'b1;
            for (int k = pos; k + 1 < used; k++)
                resident[k] = resident[k+1];
            resident[used-1] = pg;
        end
        else
        begin
            if (trace_faults != FAULT_MAX)
                trace_faults++;
            if (used < limit)
            begin
                resident[used] = pg;
                used++;
            end
            else
            begin
                r.ev_valid = 1'b1;
                r.ev_page  = resident[0];
                for (int k = 0; k + 1 < used; k++)
                    resident[k] = resident[k+1];
                resident[used-1] = pg;
            end
        end
        filled_frames = unsigned'(used);
        r.faults = trace_faults;
        r.filled = FILLED_W'(filled_frames);
        expected_outcomes.push_back(r);
        // end of trace clears after the result is formed
        if (eot)
        begin
            filled_frames = 0;
            trace_faults  = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        lru_outcome_t want;
        if (expected_outcomes.size() == 0)
        begin
            $display("%0t: result transaction with nothing expected, actual hit %0d page %0d",
                     $time, hit, evicted_page);
            mismatches++;
        end
        else
        begin
            want = expected_outcomes.pop_front();
            compare_field("hit", 32'(want.is_hit), 32'(hit));
            compare_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
            compare_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
            compare_field("fault_count", 32'(want.faults), 32'(fault_count));
            compare_field("frames_filled", 32'(want.filled), 32'(frames_filled));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg    = FRAMES_RESET;
            filled_frames = 0;
            trace_faults  = '0;
            expected_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frames_cfg = frames_in_use;
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                predict_reference(page, end_of_trace);
            outstanding <= expected_outcomes.size();
            fail_count  <= mismatches;
        end
    end

endmodule

[tb/tb.sv]
// Testbench top for the LRU page replacement block: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int          MAX_FRAME_SLOTS = 32;
    localparam int          PAGE_BITS       = 16;
    localparam int unsigned CYCLE_LIMIT     = 500_000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      frames_in_use = FRAMES_RESET;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [PAGE_BITS-1:0]  page          = '0;
    logic                  end_of_trace  = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  hit;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_count;
    logic [FILLED_W-1:0]   frames_filled;

    int unsigned           fail_count;
    int unsigned           outstanding;
    int unsigned           cycle_count   = 0;
    int unsigned           tx_idle_pct   = 0;
    int unsigned           rx_idle_pct   = 0;
    logic [CFG_W-1:0]      cur_frames    = FRAMES_RESET;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lru_page_replacement #(
        .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
        .PAGE_BITS       (PAGE_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frames_in_use (frames_in_use),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .end_of_trace  (end_of_trace),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count),
        .frames_filled (frames_filled)
    );

    lpr_checker #(
        .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS),
        .PAGE_BITS       (PAGE_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frames_in_use (frames_in_use),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .end_of_trace  (end_of_trace),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count),
        .frames_filled (frames_filled),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_stall   <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_reference(input logic [PAGE_BITS-1:0] pg, input logic eot);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        page         <= pg;
        end_of_trace <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid, then wait until every expected result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid     <= 1'b1;
        frames_in_use <= value;
        cur_frames     = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_batch(input int count);
        logic [PAGE_BITS-1:0] pool_base;
        logic [PAGE_BITS-1:0] pg;
        int                   span;
        int                   sel;
        pool_base = PAGE_BITS'($urandom);
        span = (cur_frames == '0) ? 1 : (int'(cur_frames) > MAX_FRAME_SLOTS) ? MAX_FRAME_SLOTS
                                                                             : int'(cur_frames);
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            // mostly a small working set around the frame count, so hits and evictions mix
            if (sel < 70)
                pg = pool_base + PAGE_BITS'($urandom_range(0, span + 2));
            else if (sel < 80)
                pg = $urandom_range(0, 1) ? '1 : '0;
            else
                pg = PAGE_BITS'($urandom);
            send_reference(pg, $urandom_range(0, 59) == 0);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] settings [12];
        settings = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd2, 6'd5, 6'd16, 6'd40, 6'd0, 6'd31,
                     6'd8, 6'd3};
        settings[8] = CFG_W'($urandom_range(0, 63));

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 33;
        rx_idle_pct = 85;

        // reset frame count of three: fills, LRU eviction, hits, end of trace
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'h0002, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'hAAAA, 1'b1);
        send_reference(16'h5555, 1'b1);

        // zero frames behaves as one
        write_frames(6'd0);
        send_reference(16'h0007, 1'b0);
        send_reference(16'h0007, 1'b0);
        send_reference(16'h0008, 1'b1);

        // frame count lowered with more pages resident
        write_frames(6'd32);
        for (int i = 0; i < 10; i++)
            send_reference(PAGE_BITS'(100 + i), 1'b0);
        write_frames(6'd2);
        send_reference(16'd200, 1'b0);
        send_reference(16'd105, 1'b0);
        send_reference(16'd201, 1'b1);

        for (int b = 0; b < 12; b++)
        begin
            if (b == 4)
            begin
                tx_idle_pct = 85;
                rx_idle_pct = 33;
            end
            else if (b == 8)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_frames(settings[b]);
            run_batch(58);
        end

        wait_idle();
        repeat (80)
            @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/lpr_pkg.sv
sv/lpr_frame_ram.sv
sv/lru_page_replacement.sv
tb/lpr_checker.sv
tb/tb.sv
